// File: rtl/pfb_pkg.sv
// Shared constants, opcodes and controller/datapath structs for the page framebuffer engine.
// No dependencies.
`default_nettype none

package pfb_pkg;

  localparam int WIDTH       = 128;
  localparam int HEIGHT      = 64;
  localparam int PAGES       = (HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SEQ_LEN     = 7;
  localparam int SEQ_W       = $clog2(SEQ_LEN);

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_SET      = 3'd0;
  localparam opcode_t OP_CLR      = 3'd1;
  localparam opcode_t OP_SET_SEND = 3'd2;
  localparam opcode_t OP_CLR_SEND = 3'd3;
  localparam opcode_t OP_CLR_ALL  = 3'd4;

  localparam logic [7:0] CMD_COLUMN = 8'h21;
  localparam logic [7:0] CMD_PAGE   = 8'h22;

  // controller -> datapath
  typedef struct packed {
    logic clr_write;   // one step of the clearing sweep
    logic capture;     // input transfer: latch fields, store read under way
    logic write_back;  // write modified byte
    logic load_out;    // load next byte of the sequence into the output register
  } pfb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic in_pixel;      // offered item is an on-screen pixel op
    logic in_clear_all;
    logic op_send;       // captured op sends its byte
    logic seq_last;
    logic out_free;
  } pfb_stat_t;

endpackage

`default_nettype wire

// File: rtl/pfb_if.sv
// Valid/ready channel interfaces: pixel commands in, display bytes out.
// Depends on pfb_pkg.
`default_nettype none

interface pfb_pix_if
  import pfb_pkg::*;
;
  logic       valid;
  logic       ready;
  opcode_t    opcode;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (output valid, output opcode, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input opcode, input pixel_x, input pixel_y, output ready);
endinterface

interface pfb_byte_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output is_data, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input is_data, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/page_framebuffer_pixel_engine.sv
// Pixel op without send: store read, then modify and write back.
// Pixel op with send: store read, modify and write back, then one byte per cycle of the
//   sequence while the sink keeps up; next item taken once the last byte is loaded.
// Clear whole store: sweep through the single write port, ready low meanwhile.
// Reset: synchronous, active high; runs the same clearing sweep before ready.
// Depends on pfb_pkg, pfb_if, pfb_ctrl, pfb_dpath.
`default_nettype none

module page_framebuffer_pixel_engine
  import pfb_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  pfb_pix_if.sink   pixel,
  pfb_byte_if.source disp
);

  pfb_cmd_t  cmd;
  pfb_stat_t stat;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfb_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .opcode    (pixel.opcode),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (disp.valid),
    .out_ready (disp.ready),
    .is_data   (disp.is_data),
    .out_byte  (disp.out_byte),
    .last_byte (disp.last_byte)
  );

endmodule

`default_nettype wire

// File: rtl/pfb_ctrl.sv
// Sequencing state machine: clearing sweep, read-modify-write, byte sequence.
// Depends on pfb_pkg.
`default_nettype none

module pfb_ctrl
  import pfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pfb_stat_t stat,
  output pfb_cmd_t       cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_MODIFY = 2'd2;
  localparam logic [1:0] S_SEND   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.capture    = in_fire;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (stat.in_clear_all) begin
            state_next = S_CLEAR;
          end else if (stat.in_pixel) begin
            state_next = S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        cmd.write_back = 1'b1;
        state_next     = stat.op_send ? S_SEND : S_IDLE;
      end
      S_SEND: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.seq_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pfb_dpath.sv
// Datapath: frame store memory, captured pixel fields, sweep and byte counters,
// output register. Depends on pfb_pkg.
`default_nettype none

module pfb_dpath
  import pfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire opcode_t    opcode,
  input  wire logic [7:0] pixel_x,
  input  wire logic [7:0] pixel_y,
  input  wire pfb_cmd_t   cmd,
  output pfb_stat_t       stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            is_data,
  output logic [7:0]      out_byte,
  output logic            last_byte
);

  localparam logic [SEQ_W-1:0] SEQ_COL_CMD  = SEQ_W'(0);
  localparam logic [SEQ_W-1:0] SEQ_COL_X    = SEQ_W'(1);
  localparam logic [SEQ_W-1:0] SEQ_COL_END  = SEQ_W'(2);
  localparam logic [SEQ_W-1:0] SEQ_PAGE_CMD = SEQ_W'(3);
  localparam logic [SEQ_W-1:0] SEQ_PAGE     = SEQ_W'(4);
  localparam logic [SEQ_W-1:0] SEQ_PAGE_END = SEQ_W'(5);
  localparam logic [SEQ_W-1:0] SEQ_DATA     = SEQ_W'(6);

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr;
  logic              set_pixel;
  logic              op_send;
  logic [7:0]        x;
  logic [4:0]        page;
  logic [2:0]        bit_sel;
  logic [7:0]        data;
  logic [7:0]        new_data;
  logic [SEQ_W-1:0]  seq;

  logic              on_screen;
  logic [7:0]        seq_byte;
  logic [7:0]        end_page;

  assign on_screen = ({1'b0, pixel_x} < 9'(WIDTH)) && ({1'b0, pixel_y} < 9'(HEIGHT));
  assign rd_addr   = ADDR_W'(ADDR_W'(pixel_y[7:3]) * ADDR_W'(WIDTH) + ADDR_W'(pixel_x));

  assign new_data = set_pixel ? (rd_data | (8'd1 << bit_sel))
                              : (rd_data & ~(8'd1 << bit_sel));

  assign wr_en   = cmd.clr_write || cmd.write_back;
  assign wr_addr = cmd.clr_write ? clr_addr : addr;
  assign wr_data = cmd.clr_write ? 8'd0 : new_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sweep counter wraps back to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr      <= rd_addr;
      set_pixel <= (opcode == OP_SET) || (opcode == OP_SET_SEND);
      op_send   <= (opcode == OP_SET_SEND) || (opcode == OP_CLR_SEND);
      x         <= pixel_x;
      page      <= pixel_y[7:3];
      bit_sel   <= pixel_y[2:0];
    end
    if (cmd.write_back) begin
      data <= new_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (cmd.capture) begin
      seq <= '0;
    end else if (cmd.load_out) begin
      seq <= seq + 1'b1;
    end
  end

  assign end_page = set_pixel ? 8'(PAGES - 1) : {3'b000, page};

  always_comb begin
    unique case (seq)
      SEQ_COL_CMD:  seq_byte = CMD_COLUMN;
      SEQ_COL_X:    seq_byte = x;
      SEQ_COL_END:  seq_byte = 8'(WIDTH - 1);
      SEQ_PAGE_CMD: seq_byte = CMD_PAGE;
      SEQ_PAGE:     seq_byte = {3'b000, page};
      SEQ_PAGE_END: seq_byte = end_page;
      SEQ_DATA:     seq_byte = data;
      default:      seq_byte = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte  <= seq_byte;
      is_data   <= (seq == SEQ_DATA);
      last_byte <= (seq == SEQ_DATA);
    end
  end

  always_comb begin
    stat              = '0;
    stat.clr_last     = (clr_addr == ADDR_W'(STORE_DEPTH - 1));
    stat.in_pixel     = on_screen && ((opcode == OP_SET) || (opcode == OP_CLR) ||
                        (opcode == OP_SET_SEND) || (opcode == OP_CLR_SEND));
    stat.in_clear_all = (opcode == OP_CLR_ALL);
    stat.op_send      = op_send;
    stat.seq_last     = (seq == SEQ_DATA);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// File: rtl/pfb_checker.sv
// Port-level assertions for the page framebuffer engine, bound to the top level.
// Depends on pfb_pkg.
`default_nettype none

module pfb_checker
  import pfb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire opcode_t    opcode,
  input wire logic [7:0] pixel_x,
  input wire logic [7:0] pixel_y,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte
);

  logic in_fire;
  logic on_screen;

  assign in_fire   = in_valid && in_ready;
  assign on_screen = ({1'b0, pixel_x} < 9'(WIDTH)) && ({1'b0, pixel_y} < 9'(HEIGHT));

  // a waiting byte is not withdrawn or changed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output byte dropped or changed while stalled");

  // the clearing sweep follows reset
  assert property (@(posedge clk) rst ##1 !rst |-> !in_ready)
    else $error("input taken before the clearing sweep");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && (opcode == OP_CLR_ALL) |=> !in_ready)
    else $error("input taken during a store clear");

  // read-modify-write holds the input off after an on-screen pixel transfer
  assert property (@(posedge clk) disable iff (rst)
    in_fire && on_screen && ((opcode == OP_SET) || (opcode == OP_CLR) ||
    (opcode == OP_SET_SEND) || (opcode == OP_CLR_SEND)) |=> !in_ready)
    else $error("input taken during a pixel update");

endmodule

bind page_framebuffer_pixel_engine pfb_checker u_pfb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .opcode    (pixel.opcode),
  .pixel_x   (pixel.pixel_x),
  .pixel_y   (pixel.pixel_y),
  .out_valid (disp.valid),
  .out_ready (disp.ready),
  .out_byte  (disp.out_byte)
);

`default_nettype wire

// File: tb/sv/pfb_byte_checker.sv
`timescale 1ns / 1ps
// Checker for the page framebuffer engine: keeps a shadow page store, works out the
// display bytes each pixel command should send and compares every byte transfer.
// Depends on pfb_pkg and the pfb_pix_if / pfb_byte_if channel interfaces.

module pfb_byte_checker
  import pfb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pfb_pix_if   pix_mon,
  pfb_byte_if  disp_mon,
  output int   fail_count,
  output int   due_count,
  output int   bytes_checked,
  output int   sends_seen,
  output int   pixel_cmds,
  output int   clears_seen
);

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } disp_byte_t;

  logic [7:0] shadow_store [STORE_DEPTH];
  disp_byte_t bytes_due [$];

  // Updates the shadow store and queues the seven-byte send where there is one
  task automatic apply_pixel_cmd(input opcode_t op, input logic [7:0] x, input logic [7:0] y);
    logic [4:0] page;
    int         addr;
    logic [7:0] mask;
    logic [7:0] bits;
    logic       set_px;
    logic [7:0] end_page;
    if (op == OP_CLR_ALL) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      clears_seen++;
      return;
    end
    // spare opcodes and off-screen pixels leave everything untouched
    if (op > OP_CLR_ALL || x >= WIDTH || y >= HEIGHT) return;
    pixel_cmds++;
    page   = y[7:3];
    addr   = (int'(page) * WIDTH + int'(x)) % STORE_DEPTH;
    mask   = 8'h01 << y[2:0];
    set_px = (op == OP_SET) || (op == OP_SET_SEND);
    bits   = set_px ? (shadow_store[addr] | mask) : (shadow_store[addr] & ~mask);
    shadow_store[addr] = bits;
    if (op == OP_SET || op == OP_CLR) return;
    // a set opens the page window to the bottom, a clear keeps it to one page
    end_page = set_px ? 8'(PAGES - 1) : 8'(page);
    sends_seen++;
    bytes_due.push_back('{1'b0, CMD_COLUMN, 1'b0});
    bytes_due.push_back('{1'b0, x, 1'b0});
    bytes_due.push_back('{1'b0, 8'(WIDTH - 1), 1'b0});
    bytes_due.push_back('{1'b0, CMD_PAGE, 1'b0});
    bytes_due.push_back('{1'b0, 8'(page), 1'b0});
    bytes_due.push_back('{1'b0, end_page, 1'b0});
    bytes_due.push_back('{1'b1, bits, 1'b1});
  endtask

  always @(posedge clk) begin
    disp_byte_t want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      bytes_due.delete();
    end else begin
      if (pix_mon.valid && pix_mon.ready)
        apply_pixel_cmd(pix_mon.opcode, pix_mon.pixel_x, pix_mon.pixel_y);
      if (disp_mon.valid && disp_mon.ready) begin
        bytes_checked++;
        if (bytes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected display byte data=%0b byte=%02h last=%0b", $realtime,
                     disp_mon.is_data, disp_mon.out_byte, disp_mon.last_byte);
        end else begin
          want = bytes_due.pop_front();
          if (want.is_data !== disp_mon.is_data || want.value !== disp_mon.out_byte ||
              want.last !== disp_mon.last_byte) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: display byte %0d: expected data=%0b byte=%02h last=%0b, got data=%0b byte=%02h last=%0b",
                       $realtime, bytes_checked, want.is_data, want.value, want.last,
                       disp_mon.is_data, disp_mon.out_byte, disp_mon.last_byte);
          end
        end
      end
    end
    due_count = bytes_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the page framebuffer engine testbench: clock, reset, pixel command stimulus and
// display-side back-pressure; prediction and comparison sit in pfb_byte_checker.
// Depends on pfb_pkg, the channel interfaces, the engine and the checker.

module tb_top;
  import pfb_pkg::*;

  localparam int N_RANDOM     = 307;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  // opcodes with no function
  localparam opcode_t OP_SPARE_A = 3'd5;
  localparam opcode_t OP_SPARE_B = 3'd6;
  localparam opcode_t OP_SPARE_C = 3'd7;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  logic       clk;
  logic       rst;
  int         cycle_count;
  int         burst_left;
  sink_mode_t sink_mode;
  int         sink_left;
  int         fail_count, due_count, bytes_checked, sends_seen, pixel_cmds, clears_seen;

  pfb_pix_if  pix_ch ();
  pfb_byte_if disp_ch ();

  page_framebuffer_pixel_engine i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix_ch),
    .disp  (disp_ch)
  );

  pfb_byte_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .pix_mon       (pix_ch),
    .disp_mon      (disp_ch),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .bytes_checked (bytes_checked),
    .sends_seen    (sends_seen),
    .pixel_cmds    (pixel_cmds),
    .clears_seen   (clears_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d display bytes still due", cycle_count, due_count);
      $display("tb_top failed");
      $finish;
    end
  end

  // Display side: back-pressure mode redrawn at random whenever its run counter runs out
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 96);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_OPEN:   disp_ch.ready <= 1'b1;
      SINK_COIN:   disp_ch.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: disp_ch.ready <= ($urandom_range(0, 3) == 0);
      default:     disp_ch.ready <= (sink_left % 5 != 0);
    endcase
  end

  // One pixel command transfer; called and returns at a falling edge
  task automatic put_cmd(input opcode_t op, input logic [7:0] x, input logic [7:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_ch.valid   <= 1'b0;
        pix_ch.opcode  <= opcode_t'($urandom);
        pix_ch.pixel_x <= 8'($urandom);
        pix_ch.pixel_y <= 8'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix_ch.valid   <= 1'b1;
    pix_ch.opcode  <= op;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int         done;
    int         pick;
    opcode_t    op;
    logic [7:0] x;
    logic [7:0] y;
    rst            = 1'b1;
    pix_ch.valid   = 1'b0;
    pix_ch.opcode  = OP_SET;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    disp_ch.ready  = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // corners, all opcodes, read-modify-write within one byte, off-screen and spare codes
    put_cmd(OP_SET_SEND, 8'd0, 8'd0);
    put_cmd(OP_SET_SEND, 8'(WIDTH - 1), 8'(HEIGHT - 1));
    put_cmd(OP_SET, 8'd5, 8'd9);
    put_cmd(OP_SET_SEND, 8'd5, 8'd10);
    put_cmd(OP_CLR, 8'd5, 8'd9);
    put_cmd(OP_CLR_SEND, 8'd5, 8'd10);
    put_cmd(OP_SET_SEND, 8'(WIDTH), 8'd0);
    put_cmd(OP_CLR_SEND, 8'd0, 8'(HEIGHT));
    put_cmd(OP_SET_SEND, 8'hff, 8'hff);
    put_cmd(OP_SET, 8'hff, 8'd3);
    put_cmd(OP_SPARE_A, 8'd1, 8'd1);
    put_cmd(OP_SPARE_B, 8'd0, 8'd0);
    put_cmd(OP_SPARE_C, 8'hff, 8'hff);
    put_cmd(OP_SET, 8'(WIDTH - 1), 8'(HEIGHT - 2));
    put_cmd(OP_CLR_SEND, 8'(WIDTH - 1), 8'(HEIGHT - 1));
    put_cmd(OP_SET, 8'd0, 8'd1);
    put_cmd(OP_CLR_ALL, 8'd77, 8'd200);
    put_cmd(OP_SET_SEND, 8'd0, 8'd0);
    put_cmd(OP_CLR_SEND, 8'(WIDTH - 1), 8'(HEIGHT - 2));
    put_cmd(OP_SET_SEND, 8'd0, 8'd7);
    put_cmd(OP_SET_SEND, 8'd64, 8'd56);
    put_cmd(OP_CLR_SEND, 8'd64, 8'd32);
    put_cmd(OP_CLR_SEND, 8'd0, 8'd7);

    // random part: a small hot region gets revisited so bytes build up over several commands
    done = 0;
    while (done < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      x = $urandom_range(0, 1) ? 8'($urandom_range(0, WIDTH - 1)) : 8'($urandom_range(60, 63));
      y = $urandom_range(0, 1) ? 8'($urandom_range(0, HEIGHT - 1)) : 8'($urandom_range(0, 15));
      if (pick < 2) begin
        op = OP_CLR_ALL;
      end else if (pick < 40) begin
        op = OP_SET_SEND;
      end else if (pick < 65) begin
        op = OP_CLR_SEND;
      end else if (pick < 80) begin
        op = OP_SET;
      end else if (pick < 90) begin
        op = OP_CLR;
      end else if (pick < 96) begin
        op = opcode_t'($urandom_range(OP_SET, OP_CLR_SEND));
        if ($urandom_range(0, 1))
          x = 8'($urandom_range(WIDTH, 255));
        else
          y = 8'($urandom_range(HEIGHT, 255));
      end else begin
        op = opcode_t'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      end
      put_cmd(op, x, y);
      done++;
    end
    pix_ch.valid <= 1'b0;

    while (due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d on-screen pixel commands (%0d sends) and %0d whole-store clears;",
             pixel_cmds, sends_seen, clears_seen);
    $display("%0d display bytes compared in %0d cycles, %0d failures.",
             bytes_checked, cycle_count, fail_count);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/pfb_pkg.sv
rtl/pfb_if.sv
rtl/pfb_ctrl.sv
rtl/pfb_dpath.sv
rtl/page_framebuffer_pixel_engine.sv
rtl/pfb_checker.sv
tb/sv/pfb_byte_checker.sv
tb/sv/tb_top.sv
